// File: hw/rtl/aad_pkg.sv
// aad_pkg: shared constants, types and state codes for the area average downscaler.
// Used by aad_div and area_average_downscaler; depends on nothing.
`default_nettype none
package aad_pkg;

    localparam int OUT_WIDTH      = 256;
    localparam int MAX_OUT_HEIGHT = 256;
    localparam int MAX_SRC_DIM    = 4096;

    localparam int DIM_W   = 13;   // source dimensions and positions
    localparam int OCOL_W  = 9;    // still column/row, can hold OUT_WIDTH
    localparam int SUM_W   = 18;   // per-channel box sum
    localparam int CNT_W   = 11;   // box pixel count
    localparam int DVD_W   = 22;   // divider dividend / quotient
    localparam int DVS_W   = 13;   // divider divisor
    localparam int STEP_W  = 5;    // divider step counter

    localparam logic [DIM_W-1:0] WIDTH_RESET  = 13'd1920;
    localparam logic [DIM_W-1:0] HEIGHT_RESET = 13'd1080;

    // configuration register indexes
    localparam logic CFG_SRC_WIDTH  = 1'b0;
    localparam logic CFG_SRC_HEIGHT = 1'b1;

    typedef struct packed {
        logic             start;
        logic [DVD_W-1:0] dividend;
        logic [DVS_W-1:0] divisor;
    } div_req_t;

    typedef enum logic [3:0] {
        ST_HGO,
        ST_HWAIT,
        ST_RGO,
        ST_RWAIT,
        ST_IDLE,
        ST_READ,
        ST_UPD,
        ST_MGO,
        ST_MWAIT,
        ST_OUT
    } state_t;

endpackage
`default_nettype wire

// File: hw/rtl/aad_div.sv
// aad_div: restoring divider, one quotient bit per cycle.
// Depends on aad_pkg.
`default_nettype none
module aad_div (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire aad_pkg::div_req_t        req,
    output logic                          done,
    output logic [aad_pkg::DVD_W-1:0]     quotient
);

    logic [aad_pkg::DVS_W-1:0]  rem_reg;
    logic [aad_pkg::DVD_W-1:0]  quo_reg;
    logic [aad_pkg::DVS_W-1:0]  dvs_reg;
    logic [aad_pkg::STEP_W-1:0] step_reg;
    logic                       busy_reg;
    logic                       done_reg;

    logic [aad_pkg::DVS_W:0]    shifted;
    logic [aad_pkg::DVS_W+1:0]  diff;
    logic                       ge;

    assign shifted = {rem_reg, quo_reg[aad_pkg::DVD_W-1]};
    assign diff    = {1'b0, shifted} - {2'b00, dvs_reg};
    assign ge      = ~diff[aad_pkg::DVS_W+1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
            end
            else if (busy_reg && step_reg == '0)
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            rem_reg  <= '0;
            quo_reg  <= req.dividend;
            dvs_reg  <= req.divisor;
            step_reg <= aad_pkg::STEP_W'(aad_pkg::DVD_W - 1);
        end
        else if (busy_reg)
        begin
            rem_reg  <= ge ? diff[aad_pkg::DVS_W-1:0] : shifted[aad_pkg::DVS_W-1:0];
            quo_reg  <= {quo_reg[aad_pkg::DVD_W-2:0], ge};
            step_reg <= step_reg - 1'b1;
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule
`default_nettype wire

// File: hw/rtl/area_average_downscaler.sv
// area_average_downscaler: box-filter shrink of a raster RGB frame to a 256 wide still.
// Depends on aad_pkg and aad_div.
`default_nettype none
//
//  channel | signals                                       | transfer
//  --------+-----------------------------------------------+-------------------------
//  in      | in_valid/in_ready, frame_start, src_red/green/blue | valid & ready
//  out     | out_valid/out_ready, out_x/y, out_red/green/blue, out_last | valid & ready
//  cfg     | cfg_we, cfg_index, cfg_data                   | cfg_we, no wait
//
// A pixel transaction passes through the idle, read and update states when it closes no box.
// Each divide runs an issue state, 22 divider steps and a done state. A pixel closing a box
// adds three divides for the means and an output state; a row-box change adds one divide for
// the next row bound; a frame start adds two (still height and first row bound).
// After reset the block computes the first frame's geometry before taking pixels.
// A held output transaction only blocks the next closing pixel.
module area_average_downscaler (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic       frame_start,
    input  wire logic [7:0] src_red,
    input  wire logic [7:0] src_green,
    input  wire logic [7:0] src_blue,
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic [7:0]      out_x,
    output logic [7:0]      out_y,
    output logic [7:0]      out_red,
    output logic [7:0]      out_green,
    output logic [7:0]      out_blue,
    output logic            out_last,
    input  wire logic       cfg_we,
    input  wire logic       cfg_index,
    input  wire logic [12:0] cfg_data
);

    localparam int DW = aad_pkg::DIM_W;
    localparam int CW = aad_pkg::OCOL_W;
    localparam int SW = aad_pkg::SUM_W;

    aad_pkg::state_t state_reg, state_next;

    // configuration
    logic [DW-1:0] cfg_w_reg, cfg_h_reg;

    // frame geometry
    logic [DW-1:0] lat_w_reg, lat_h_reg;
    logic [CW-1:0] still_h_reg;
    logic [DW-1:0] src_col_reg, src_row_reg;
    logic [CW-1:0] out_col_reg, out_row_reg;
    logic [DW-1:0] col_start_reg, col_end_reg, row_start_reg, row_end_reg;
    logic          frame_done_reg, pix_pend_reg, row_pend_reg;

    // current pixel
    logic [7:0]    pix_reg [3];

    // column sums memory, valid bit per entry
    logic [3*SW-1:0]        mem [aad_pkg::OUT_WIDTH];
    logic [aad_pkg::OUT_WIDTH-1:0] vld_reg;
    logic [3*SW-1:0]        rd_data_reg;
    logic                   rd_vld_reg;

    // box finish
    logic [SW-1:0]              sum_reg [3];
    logic [aad_pkg::CNT_W-1:0]  cnt_reg;
    logic [7:0]                 mean_reg [3];
    logic [1:0]                 ch_reg;
    logic [7:0]                 ex_reg, ey_reg;
    logic                       elast_reg;

    // output register
    logic       out_valid_reg;
    logic [7:0] out_x_reg, out_y_reg, out_r_reg, out_g_reg, out_b_reg;
    logic       out_last_reg;

    // divider
    aad_pkg::div_req_t         div_req;
    logic                      div_done;
    logic [aad_pkg::DVD_W-1:0] div_q;

    aad_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (div_req),
        .done     (div_done),
        .quotient (div_q)
    );

    // clamped register values for frame start
    logic [DW-1:0] w_clamp, h_clamp;
    always_comb
    begin
        w_clamp = cfg_w_reg;
        if (cfg_w_reg < DW'(aad_pkg::OUT_WIDTH))   w_clamp = DW'(aad_pkg::OUT_WIDTH);
        if (cfg_w_reg > DW'(aad_pkg::MAX_SRC_DIM)) w_clamp = DW'(aad_pkg::MAX_SRC_DIM);
        h_clamp = cfg_h_reg;
        if (cfg_h_reg == '0)                        h_clamp = DW'(1);
        if (cfg_h_reg > DW'(aad_pkg::MAX_SRC_DIM)) h_clamp = DW'(aad_pkg::MAX_SRC_DIM);
    end

    // update-step decisions
    logic [SW-1:0] sum_new [3];
    logic [DW-1:0] src_col_inc, src_row_inc;
    logic [CW-1:0] out_row_inc;
    logic          col_hit, row_hit, emit, row_wrap, is_last, row_done, need_row;
    logic [22:0]   col_bound_prod;
    logic [DW-1:0] bw, bh;
    logic [CW-1:0] out_col_p2;

    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            sum_new[c] = (rd_vld_reg ? rd_data_reg[c*SW +: SW] : SW'(0))
                         + SW'(pix_reg[c]);
        end
        src_col_inc = src_col_reg + 1'b1;
        src_row_inc = src_row_reg + 1'b1;
        out_row_inc = out_row_reg + 1'b1;
        col_hit  = src_col_inc >= col_end_reg;
        row_hit  = src_row_inc >= row_end_reg;
        emit     = col_hit && row_hit;
        row_wrap = src_col_inc >= lat_w_reg;
        is_last  = (out_col_reg == CW'(aad_pkg::OUT_WIDTH - 1)) && (out_row_inc == still_h_reg);
        row_done = out_row_inc >= still_h_reg;
        need_row = row_wrap && row_hit && !row_done;
        out_col_p2     = out_col_reg + CW'(2);
        col_bound_prod = 23'({1'b0, out_col_p2}) * 23'(lat_w_reg);
        bw = col_end_reg - col_start_reg;
        bh = row_end_reg - row_start_reg;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            aad_pkg::ST_HGO:   state_next = aad_pkg::ST_HWAIT;
            aad_pkg::ST_HWAIT: if (div_done) state_next = aad_pkg::ST_RGO;
            aad_pkg::ST_RGO:   state_next = aad_pkg::ST_RWAIT;
            aad_pkg::ST_RWAIT:
                if (div_done)
                    state_next = pix_pend_reg ? aad_pkg::ST_READ : aad_pkg::ST_IDLE;
            aad_pkg::ST_IDLE:
                if (in_valid)
                begin
                    if (frame_start)         state_next = aad_pkg::ST_HGO;
                    else if (!frame_done_reg) state_next = aad_pkg::ST_READ;
                end
            aad_pkg::ST_READ:  state_next = aad_pkg::ST_UPD;
            aad_pkg::ST_UPD:
                if (emit)          state_next = aad_pkg::ST_MGO;
                else if (need_row) state_next = aad_pkg::ST_RGO;
                else               state_next = aad_pkg::ST_IDLE;
            aad_pkg::ST_MGO:   state_next = aad_pkg::ST_MWAIT;
            aad_pkg::ST_MWAIT:
                if (div_done)
                    state_next = (ch_reg == 2'd2) ? aad_pkg::ST_OUT : aad_pkg::ST_MGO;
            aad_pkg::ST_OUT:
                if (!out_valid_reg || out_ready)
                    state_next = row_pend_reg ? aad_pkg::ST_RGO : aad_pkg::ST_IDLE;
            default:           state_next = aad_pkg::ST_HGO;
        endcase
    end

    // outputs of the sequencer
    always_comb
    begin
        in_ready = 1'b0;
        div_req  = '0;
        case (state_reg)
            aad_pkg::ST_IDLE: in_ready = 1'b1;
            aad_pkg::ST_HGO:
            begin
                div_req.start    = 1'b1;
                div_req.dividend = aad_pkg::DVD_W'({h_clamp, 8'h00});
                div_req.divisor  = w_clamp;
            end
            aad_pkg::ST_RGO:
            begin
                div_req.start    = 1'b1;
                div_req.dividend = aad_pkg::DVD_W'(23'({1'b0, out_row_inc}) * 23'(lat_h_reg));
                div_req.divisor  = aad_pkg::DVS_W'(still_h_reg);
            end
            aad_pkg::ST_MGO:
            begin
                div_req.start    = 1'b1;
                div_req.dividend = aad_pkg::DVD_W'(sum_reg[ch_reg]);
                div_req.divisor  = (cnt_reg == '0) ? aad_pkg::DVS_W'(1)
                                                   : aad_pkg::DVS_W'(cnt_reg);
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= aad_pkg::ST_HGO;
        else
            state_reg <= state_next;
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_w_reg <= aad_pkg::WIDTH_RESET;
            cfg_h_reg <= aad_pkg::HEIGHT_RESET;
        end
        else if (cfg_we)
        begin
            if (cfg_index == aad_pkg::CFG_SRC_WIDTH) cfg_w_reg <= cfg_data;
            if (cfg_index == aad_pkg::CFG_SRC_HEIGHT) cfg_h_reg <= cfg_data;
        end
    end

    // sums memory: sync read, write on update
    always_ff @(posedge clk)
    begin
        if (state_reg == aad_pkg::ST_READ)
            rd_data_reg <= mem[out_col_reg[7:0]];
        if (state_reg == aad_pkg::ST_UPD && !emit)
            mem[out_col_reg[7:0]] <= {sum_new[2], sum_new[1], sum_new[0]};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg    <= '0;
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            if (state_reg == aad_pkg::ST_READ)
                rd_vld_reg <= vld_reg[out_col_reg[7:0]];
            if (state_reg == aad_pkg::ST_HGO)
                vld_reg <= '0;
            else if (state_reg == aad_pkg::ST_UPD)
                vld_reg[out_col_reg[7:0]] <= !emit;
        end
    end

    // frame control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_done_reg <= 1'b0;
            pix_pend_reg   <= 1'b0;
            row_pend_reg   <= 1'b0;
            src_col_reg    <= '0;
            src_row_reg    <= '0;
            out_col_reg    <= '0;
            out_row_reg    <= '0;
            ch_reg         <= '0;
        end
        else
        begin
            case (state_reg)
                aad_pkg::ST_HGO:
                begin
                    frame_done_reg <= 1'b0;
                    row_pend_reg   <= 1'b0;
                    src_col_reg    <= '0;
                    src_row_reg    <= '0;
                    out_col_reg    <= '0;
                    out_row_reg    <= '0;
                end
                aad_pkg::ST_IDLE:
                    if (in_valid)
                        pix_pend_reg <= frame_start;
                aad_pkg::ST_READ:
                    pix_pend_reg <= 1'b0;
                aad_pkg::ST_RWAIT:
                    if (div_done)
                        row_pend_reg <= 1'b0;
                aad_pkg::ST_UPD:
                begin
                    ch_reg       <= '0;
                    row_pend_reg <= need_row;
                    if (emit && is_last)
                        frame_done_reg <= 1'b1;
                    if (row_wrap)
                    begin
                        src_col_reg <= '0;
                        out_col_reg <= '0;
                        src_row_reg <= src_row_inc;
                        if (row_hit)
                        begin
                            out_row_reg <= out_row_inc;
                            if (row_done)
                                frame_done_reg <= 1'b1;
                        end
                    end
                    else
                    begin
                        src_col_reg <= src_col_inc;
                        if (col_hit)
                            out_col_reg <= out_col_reg + 1'b1;
                    end
                end
                aad_pkg::ST_MWAIT:
                    if (div_done)
                        ch_reg <= ch_reg + 1'b1;
                default: ;
            endcase
        end
    end

    // geometry and payload registers
    always_ff @(posedge clk)
    begin
        case (state_reg)
            aad_pkg::ST_HGO:
            begin
                lat_w_reg     <= w_clamp;
                lat_h_reg     <= h_clamp;
                col_start_reg <= '0;
                col_end_reg   <= DW'(w_clamp >> 8);
                row_start_reg <= '0;
            end
            aad_pkg::ST_HWAIT:
                if (div_done)
                begin
                    if (div_q == '0)
                        still_h_reg <= CW'(1);
                    else if (div_q > aad_pkg::DVD_W'(aad_pkg::MAX_OUT_HEIGHT))
                        still_h_reg <= CW'(aad_pkg::MAX_OUT_HEIGHT);
                    else
                        still_h_reg <= div_q[CW-1:0];
                end
            aad_pkg::ST_RWAIT:
                if (div_done)
                    row_end_reg <= div_q[DW-1:0];
            aad_pkg::ST_IDLE:
                if (in_valid)
                begin
                    pix_reg[0] <= src_red;
                    pix_reg[1] <= src_green;
                    pix_reg[2] <= src_blue;
                end
            aad_pkg::ST_UPD:
            begin
                if (emit)
                begin
                    ex_reg     <= out_col_reg[7:0];
                    ey_reg     <= out_row_reg[7:0];
                    elast_reg  <= is_last;
                    sum_reg[0] <= sum_new[0];
                    sum_reg[1] <= sum_new[1];
                    sum_reg[2] <= sum_new[2];
                    cnt_reg    <= aad_pkg::CNT_W'(bw[4:0]) * aad_pkg::CNT_W'(bh[6:0]);
                end
                if (row_wrap)
                begin
                    col_start_reg <= '0;
                    col_end_reg   <= DW'(lat_w_reg >> 8);
                    if (row_hit)
                        row_start_reg <= row_end_reg;
                end
                else if (col_hit)
                begin
                    col_start_reg <= col_end_reg;
                    col_end_reg   <= col_bound_prod[DW+7:8];
                end
            end
            aad_pkg::ST_MWAIT:
                if (div_done)
                    mean_reg[ch_reg] <= div_q[7:0];
            default: ;
        endcase
    end

    // output register; frees the sequencer while a result waits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (state_reg == aad_pkg::ST_OUT && (!out_valid_reg || out_ready))
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == aad_pkg::ST_OUT && (!out_valid_reg || out_ready))
        begin
            out_x_reg    <= ex_reg;
            out_y_reg    <= ey_reg;
            out_r_reg    <= mean_reg[0];
            out_g_reg    <= mean_reg[1];
            out_b_reg    <= mean_reg[2];
            out_last_reg <= elast_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_x     = out_x_reg;
    assign out_y     = out_y_reg;
    assign out_red   = out_r_reg;
    assign out_green = out_g_reg;
    assign out_blue  = out_b_reg;
    assign out_last  = out_last_reg;

endmodule
`default_nettype wire

// File: tb/aad_checker.sv
// aad_checker: watches the pixel, still and register ports of the downscaler,
// predicts every still pixel and compares it field by field. Depends on aad_pkg.
module aad_checker (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    input  wire logic        in_ready,
    input  wire logic        frame_start,
    input  wire logic [7:0]  src_red,
    input  wire logic [7:0]  src_green,
    input  wire logic [7:0]  src_blue,
    input  wire logic        out_valid,
    input  wire logic        out_ready,
    input  wire logic [7:0]  out_x,
    input  wire logic [7:0]  out_y,
    input  wire logic [7:0]  out_red,
    input  wire logic [7:0]  out_green,
    input  wire logic [7:0]  out_blue,
    input  wire logic        out_last,
    input  wire logic        cfg_we,
    input  wire logic        cfg_index,
    input  wire logic [12:0] cfg_data,
    output int               errors,
    output int               pending
);
    import aad_pkg::*;

    typedef struct {
        logic [7:0] x;
        logic [7:0] y;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       last;
    } still_pixel_t;

    still_pixel_t expected_pixels[$];

    logic [DIM_W-1:0] width_reg, height_reg;
    int box_sums[OUT_WIDTH][3];
    int eff_w, eff_h, still_h, col_end, row_end;
    int src_col, src_row, out_col, out_row;
    bit still_done;

    function automatic int col_lim(int x);
        return (x * eff_w) / OUT_WIDTH;
    endfunction

    function automatic int row_lim(int y);
        return (y * eff_h) / still_h;
    endfunction

    function void begin_frame();
        int t;
        eff_w = width_reg;
        eff_h = height_reg;
        if (eff_w < OUT_WIDTH) eff_w = OUT_WIDTH;
        if (eff_w > MAX_SRC_DIM) eff_w = MAX_SRC_DIM;
        if (eff_h < 1) eff_h = 1;
        if (eff_h > MAX_SRC_DIM) eff_h = MAX_SRC_DIM;
        t = (OUT_WIDTH * eff_h) / eff_w;
        if (t < 1) t = 1;
        if (t > MAX_OUT_HEIGHT) t = MAX_OUT_HEIGHT;
        still_h = t;
        foreach (box_sums[i, c]) box_sums[i][c] = 0;
        src_col = 0;
        src_row = 0;
        out_col = 0;
        out_row = 0;
        col_end = col_lim(1);
        row_end = row_lim(1);
        still_done = 0;
    endfunction

    function void shrink_pixel(logic fs, logic [7:0] r, logic [7:0] g, logic [7:0] b);
        still_pixel_t p;
        int cnt;
        if (fs) begin_frame();
        if (still_done || out_col >= OUT_WIDTH) return;
        box_sums[out_col][0] += r;
        box_sums[out_col][1] += g;
        box_sums[out_col][2] += b;
        src_col++;
        if (src_col >= col_end)
        begin
            if (src_row + 1 >= row_end)
            begin
                cnt = (col_end - col_lim(out_col)) * (row_end - row_lim(out_row));
                if (cnt == 0) cnt = 1;
                p.x     = out_col[7:0];
                p.y     = out_row[7:0];
                p.red   = 8'(box_sums[out_col][0] / cnt);
                p.green = 8'(box_sums[out_col][1] / cnt);
                p.blue  = 8'(box_sums[out_col][2] / cnt);
                p.last  = (out_col == OUT_WIDTH - 1) && (out_row + 1 == still_h);
                for (int c = 0; c < 3; c++) box_sums[out_col][c] = 0;
                expected_pixels.push_back(p);
                if (p.last) still_done = 1;
            end
            out_col++;
            if (out_col < OUT_WIDTH) col_end = col_lim(out_col + 1);
        end
        if (src_col >= eff_w)
        begin
            src_col = 0;
            out_col = 0;
            col_end = col_lim(1);
            src_row++;
            if (src_row >= row_end)
            begin
                out_row++;
                if (out_row >= still_h) still_done = 1;
                else row_end = row_lim(out_row + 1);
            end
        end
    endfunction

    task automatic report_mismatch(string what);
        $display("[%0t] mismatch: %s", $realtime, what);
        errors++;
    endtask

    initial errors = 0;
    assign pending = expected_pixels.size();

    always @(posedge clk or negedge rst_n)
    begin
        still_pixel_t e;
        if (!rst_n)
        begin
            width_reg  = WIDTH_RESET;
            height_reg = HEIGHT_RESET;
            begin_frame();
            expected_pixels.delete();
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == CFG_SRC_WIDTH) width_reg = cfg_data;
                else height_reg = cfg_data;
            end
            if (in_valid && in_ready)
                shrink_pixel(frame_start, src_red, src_green, src_blue);
            if (out_valid && out_ready)
            begin
                if (expected_pixels.size() == 0)
                    report_mismatch($sformatf("unexpected pixel x=%0d y=%0d", out_x, out_y));
                else
                begin
                    e = expected_pixels.pop_front();
                    if (out_x !== e.x || out_y !== e.y || out_last !== e.last)
                        report_mismatch($sformatf("pos/last got %0d,%0d,%0b exp %0d,%0d,%0b",
                            out_x, out_y, out_last, e.x, e.y, e.last));
                    if (out_red !== e.red || out_green !== e.green || out_blue !== e.blue)
                        report_mismatch($sformatf("rgb at %0d,%0d got %h%h%h exp %h%h%h",
                            e.x, e.y, out_red, out_green, out_blue, e.red, e.green, e.blue));
                end
            end
        end
    end
endmodule

// File: tb/tb_top.sv
// tb_top: stimulus, clock, reset and verdict for area_average_downscaler.
// Depends on aad_pkg, the RTL and aad_checker (which checks every still pixel).
module tb_top;
    import aad_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic        frame_start;
    logic [7:0]  src_red, src_green, src_blue;
    logic        out_valid;
    logic        out_ready;
    logic [7:0]  out_x, out_y, out_red, out_green, out_blue;
    logic        out_last;
    logic        cfg_we;
    logic        cfg_index;
    logic [12:0] cfg_data;
    int          errors;
    int          pending;

    int  pixels_sent;
    int  idle_cycles;
    bit  no_gaps;      // burst mode: in_valid stays high between pixels, no inserted gaps

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int TARGET_PIXELS  = 1100;
    // pause so the divides for frame geometry and box means can finish
    localparam int SETTLE_CYCLES  = 300;

    area_average_downscaler dut (.*);

    aad_checker checker_i (.*);

    initial
    begin
        clk = 0;
        forever #4 clk = ~clk;
    end

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        if ($urandom_range(0, 19) == 0) return $urandom_range(20, 60);
        return $urandom_range(0, 3);
    endfunction

    function automatic logic [7:0] pick_color();
        case ($urandom_range(0, 7))
            0: return 8'h00;
            1: return 8'hFF;
            default: return 8'($urandom);
        endcase
    endfunction

    // receiver side: random stalls, with stretches of always-ready
    initial
    begin
        out_ready = 0;
        @(posedge rst_n);
        forever
        begin
            out_ready <= 1;
            repeat ($urandom_range(1, 30)) @(posedge clk);
            if ($urandom_range(0, 2) != 0)
            begin
                out_ready <= 0;
                repeat (pick_gap() + 1) @(posedge clk);
            end
        end
    end

    // counts cycles with no transaction on either channel; fails the run at WATCHDOG_LIMIT
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    // one pixel transaction; called and returns at a rising edge
    task automatic send_pixel(logic fs, logic [7:0] r, logic [7:0] g, logic [7:0] b);
        int gap;
        gap = no_gaps ? 0 : pick_gap();
        if (gap > 0)
        begin
            in_valid <= 0;
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1;
        frame_start <= fs;
        src_red     <= r;
        src_green   <= g;
        src_blue    <= b;
        forever
        begin
            @(negedge clk);
            if (in_ready)
            begin
                @(posedge clk);
                break;
            end
        end
        pixels_sent++;
    endtask

    // drain outstanding stills, let the block go quiet, then load both registers
    task automatic set_geometry(logic [12:0] w, logic [12:0] h);
        in_valid <= 0;
        wait (pending == 0);
        @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_we    <= 1;
        cfg_index <= CFG_SRC_WIDTH;
        cfg_data  <= w;
        @(posedge clk);
        cfg_index <= CFG_SRC_HEIGHT;
        cfg_data  <= h;
        @(posedge clk);
        cfg_we    <= 0;
        @(posedge clk);
    endtask

    initial
    begin
        logic [12:0] widths[8]  = '{13'd256, 13'd0, 13'd8191, 13'd4096,
                                    13'd257, 13'd300, 13'd511, 13'd320};
        logic [12:0] heights[8] = '{13'd1, 13'd0, 13'd4096, 13'd8191,
                                    13'd2, 13'd3, 13'd5, 13'd1};
        logic [12:0] w, h;
        int ew, eh, n;
        bit fresh;

        rst_n       = 0;
        in_valid    = 0;
        frame_start = 0;
        src_red     = 0;
        src_green   = 0;
        src_blue    = 0;
        cfg_we      = 0;
        cfg_index   = CFG_SRC_WIDTH;
        cfg_data    = 0;
        pixels_sent = 0;
        no_gaps     = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // no frame start after reset: default 1920x1080 geometry, extreme colors
        for (int i = 0; i < 6; i++)
            send_pixel(0, (i & 1) ? 8'hFF : 8'h00, (i & 2) ? 8'hFF : 8'h00,
                       (i & 4) ? 8'hFF : 8'h00);

        // one-pixel boxes: every pixel closes a box
        set_geometry(13'd256, 13'd1);
        send_pixel(1, 8'hFF, 8'hFF, 8'hFF);
        for (int i = 0; i < 8; i++)
            send_pixel(0, 8'($urandom), (i & 1) ? 8'h00 : 8'hFF, 8'($urandom));

        // full 256x1 frame, its last pixel, and pixels past the end of the still
        set_geometry(13'd256, 13'd1);
        send_pixel(1, pick_color(), pick_color(), pick_color());
        for (int i = 1; i < 262; i++)
            send_pixel(0, pick_color(), pick_color(), pick_color());

        while (pixels_sent < TARGET_PIXELS)
        begin
            w = ($urandom_range(0, 3) == 0) ? 13'($urandom_range(256, 700))
                                            : widths[$urandom_range(0, 7)];
            h = ($urandom_range(0, 3) == 0) ? 13'($urandom_range(1, 8))
                                            : heights[$urandom_range(0, 7)];
            set_geometry(w, h);
            no_gaps = ($urandom_range(0, 3) == 0);
            ew = (w < 256) ? 256 : (w > 4096) ? 4096 : w;
            eh = (h < 1) ? 1 : (h > 4096) ? 4096 : h;
            // without a frame start the previous geometry stays latched
            fresh = ($urandom_range(0, 4) != 0);
            n = $urandom_range(20, 150);
            if (ew * eh <= 700 && $urandom_range(0, 3) == 0) n = ew * eh + 4;
            // keep the total near the target
            if (n > TARGET_PIXELS - pixels_sent) n = TARGET_PIXELS - pixels_sent;
            for (int i = 0; i < n; i++)
                send_pixel((i == 0 && fresh) || ($urandom_range(0, 99) == 0),
                           pick_color(), pick_color(), pick_color());
        end

        in_valid <= 0;
        wait (pending == 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (errors == 0 && pending == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end
endmodule
